// ===== rtl/kmcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kmcd_pkg: shared constants for the key matrix change detector
// Command codes, register indexes, reset values and stream field widths.
// ---------------------------------------------------------------------------
package kmcd_pkg;

  // command codes carried on s_tuser
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_GATED   = 2'd1;
  localparam logic [1:0] CMD_UNGATED = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // configuration register indexes
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_ACTIVE   = 1'b1;

  localparam int CFG_DATA_W = 16;
  localparam int ELAPSED_W  = 16;

  localparam logic [15:0]        DEBOUNCE_RESET = 16'd50;
  localparam logic [3:0]         ACTIVE_RESET   = 4'd8;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = {ELAPSED_W{1'b1}};

  // field widths
  localparam int ROW_W    = 3;
  localparam int SAMPLE_W = 8;
  localparam int EVCOL_W  = 3;

endpackage : kmcd_pkg
`default_nettype wire

// ===== rtl/key_matrix_change_detector_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// key_matrix_change_detector_top: keyboard matrix change detector
// Keeps the last column levels of each row in a small RAM and reports one
// beat per changed column, lowest column first, when a row sample is taken.
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser cmd, tdata row_index, column_sample
//  m_*      out  m_tvalid/m_tready  tdata event_row, event_column,
//                                   tuser released, tlast last
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// A tick, an unused command, a dropped or out-of-range sample leaves the block idle.
// A taken sample is read from the RAM, compared and written back, then the
// changed columns are scanned, lowest first; no scan runs when nothing changed.
// s_tready stays low until the block is idle again.
// Each changed column waits in the scan until the output register is free.
// rst is synchronous; the row RAM reads as all ones until a row is written
// (per-row valid bits), so no clearing pass is needed.
// ---------------------------------------------------------------------------
module key_matrix_change_detector_top
  import kmcd_pkg::*;
#(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [15:0]           s_tdata,   // [2:0] row_index, [10:3] column_sample
  input  wire logic [1:0]            s_tuser,   // [1:0] cmd
  // result stream
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [7:0]            m_tdata,   // [2:0] event_row, [5:3] event_column
  output      logic                  m_tuser,   // [0] released
  output      logic                  m_tlast,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]            state;
  logic [15:0]           debounce_ticks;
  logic [3:0]            active_columns;
  logic [ELAPSED_W-1:0]  elapsed;

  logic [COLS-1:0]       mem [ROWS];
  logic [ROWS-1:0]       row_valid;
  logic [COLS-1:0]       rd_data;
  logic                  rd_valid;

  logic [AW-1:0]         cur_addr;
  logic [ROW_W-1:0]      cur_row;
  logic [COLS-1:0]       cur_sample;
  logic [COLS-1:0]       changed;
  logic [CW-1:0]         col;

  // input decode
  logic                  accept;
  logic [1:0]            in_cmd;
  logic [ROW_W-1:0]      in_row;
  logic [COLS-1:0]       col_mask;
  logic [COLS-1:0]       masked_sample;
  logic                  row_ok;
  logic                  gate_open;
  logic                  take;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_cmd   = s_tuser;
  assign in_row   = s_tdata[ROW_W-1:0];

  always_comb begin
    for (int i = 0; i < COLS; i++) begin
      col_mask[i] = (i < int'(active_columns));
    end
  end

  assign masked_sample = COLS'(s_tdata[ROW_W+SAMPLE_W-1:ROW_W]) & col_mask;
  assign row_ok        = (int'(in_row) < ROWS);
  assign gate_open     = (elapsed > debounce_ticks);
  assign take          = accept && row_ok &&
                         ((in_cmd == CMD_UNGATED) || ((in_cmd == CMD_GATED) && gate_open));

  // compare against stored row; inactive columns never report
  logic [COLS-1:0] stored;
  logic [COLS-1:0] diff;
  assign stored = rd_valid ? rd_data : {COLS{1'b1}};
  assign diff   = (stored ^ cur_sample) & col_mask;

  // column scan
  logic [COLS-1:0] col_bit;
  logic [COLS-1:0] rest;
  logic            out_free;
  logic            load;
  assign col_bit  = COLS'(1) << col;
  assign rest     = changed & ~col_bit;
  assign out_free = !m_tvalid || m_tready;
  assign load     = (state == ST_SCAN) && changed[col] && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
      active_columns <= ACTIVE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_ticks <= cfg_data[15:0];
        REG_ACTIVE:   active_columns <= cfg_data[3:0];
        default:      ;
      endcase
    end
  end

  // elapsed counter
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (accept && (in_cmd == CMD_TICK)) begin
      if (elapsed != ELAPSED_MAX) begin
        elapsed <= elapsed + 1'b1;
      end
    end else if (take && (in_cmd == CMD_GATED)) begin
      elapsed <= '0;
    end
  end

  // row RAM: read on take, write back in the compare cycle
  always_ff @(posedge clk) begin
    if (take) begin
      rd_data <= mem[AW'(in_row)];
    end
    if (state == ST_READ) begin
      mem[cur_addr] <= cur_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (take) begin
        rd_valid <= row_valid[AW'(in_row)];
      end
      if (state == ST_READ) begin
        row_valid[cur_addr] <= 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= (diff != '0) ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (load && (rest == '0)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_addr   <= AW'(in_row);
      cur_row    <= in_row;
      cur_sample <= masked_sample;
    end
    if (state == ST_READ) begin
      changed <= diff;
      col     <= '0;
    end else if (state == ST_SCAN) begin
      if (changed[col]) begin
        if (out_free) begin
          changed <= rest;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {2'b00, EVCOL_W'(col), cur_row};
      m_tuser <= cur_sample[col];
      m_tlast <= (rest == '0);
    end
  end

  // checks
  a_scan_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (changed != '0))
    else $error("scan running with no changed column");

  a_scan_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (int'(col) < COLS))
    else $error("column index past last column");

  a_one_bit_per_beat: assert property (@(posedge clk) disable iff (rst)
    load |=> ($countones(changed) == $past($countones(changed)) - 1))
    else $error("emitted beat did not retire exactly one column");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (rst)
    (load && (rest == '0)) |=> (state == ST_IDLE) && m_tvalid && m_tlast)
    else $error("last beat did not end the scan");

endmodule : key_matrix_change_detector_top
`default_nettype wire

// ===== verif/tb_key_matrix_change_detector_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_key_matrix_change_detector_top: self-checking bench for the key matrix
// change detector
// Drives tick and row-sample commands and predicts the key events each one
// should raise, using a row-level and tick-counter model kept in the bench.
// Every event beat is checked field by field, in order. Three idle phases,
// one long output stall and a short tick run around the debounce threshold.
// ---------------------------------------------------------------------------
module tb_key_matrix_change_detector_top;
  import kmcd_pkg::*;

  localparam int SETTLE_CYCLES = 16;  // margin after the last event beat
  localparam int STALL_CYCLES  = 300;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       released;
    logic       last;
  } kbd_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;    // [2:0] row_index, [10:3] column_sample
  logic [1:0]            s_tuser = CMD_TICK;  // [1:0] cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;         // [2:0] event_row, [5:3] event_column
  logic                  m_tuser;         // [0] released
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  key_matrix_change_detector_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // matrix model
  logic [7:0]           model_levels [8];
  logic [ELAPSED_W-1:0] model_elapsed;
  logic [15:0]          model_debounce;
  logic [3:0]           model_active;
  kbd_event_t           pending_events [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_request = 0;
  int stall_left    = 0;
  int mismatches     = 0;
  int beats_sent     = 0;
  int scan_cmds      = 0;
  int events_checked = 0;
  int reg_writes     = 0;

  function automatic void predict_key_events(input logic [1:0] cmd, input logic [2:0] row,
                                             input logic [7:0] sample);
    logic [3:0] ncols;
    logic [8:0] mask;
    logic [7:0] taken;
    logic [7:0] changed;
    kbd_event_t ev;
    case (cmd)
      CMD_TICK: begin
        if (model_elapsed != ELAPSED_MAX) model_elapsed++;
      end
      CMD_GATED, CMD_UNGATED: begin
        if (cmd == CMD_GATED) begin
          if (model_elapsed <= model_debounce) return;
          model_elapsed = '0;
        end
        ncols   = (model_active > 4'd8) ? 4'd8 : model_active;
        mask    = (9'd1 << ncols) - 9'd1;
        taken   = sample & mask[7:0];
        changed = (model_levels[row] ^ taken) & mask[7:0];
        for (int c = 0; c < 8; c++) begin
          if (changed[c]) begin
            changed[c]  = 1'b0;
            ev.row      = row;
            ev.col      = 3'(c);
            ev.released = taken[c];
            ev.last     = (changed == 8'd0);
            pending_events.push_back(ev);
          end
        end
        model_levels[row] = taken;
      end
      default: ;
    endcase
  endfunction

  // one beat on the input stream; tvalid stays up for a back-to-back beat
  task automatic send_item(input logic [1:0] cmd, input logic [2:0] row,
                           input logic [7:0] sample);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {5'd0, sample, row};
    do @(posedge clk); while (!s_tready);
    predict_key_events(cmd, row, sample);
    beats_sent++;
    if (cmd != CMD_NONE) scan_cmds++;
  endtask

  // stop sending and let every expected event come out
  task automatic settle_results();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    settle_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEBOUNCE) model_debounce = value;
    else model_active = value[3:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_request != 0) begin
      stall_left = stall_request - 1;
      stall_request = 0;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    kbd_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        $error("unexpected event beat: row %0d column %0d", m_tdata[2:0], m_tdata[5:3]);
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (m_tdata[2:0] !== want.row) begin
          mismatches++;
          $error("event_row: expected %0d, got %0d", want.row, m_tdata[2:0]);
        end
        if (m_tdata[5:3] !== want.col) begin
          mismatches++;
          $error("event_column: expected %0d, got %0d", want.col, m_tdata[5:3]);
        end
        if (m_tuser !== want.released) begin
          mismatches++;
          $error("released: expected %0d, got %0d", want.released, m_tuser);
        end
        if (m_tlast !== want.last) begin
          mismatches++;
          $error("last: expected %0d, got %0d", want.last, m_tlast);
        end
      end
    end
  end

  task automatic test_reset_levels();
    send_item(CMD_UNGATED, 3'd0, 8'hFF);  // matches reset levels: quiet
    send_item(CMD_UNGATED, 3'd0, 8'h00);  // every key down
    send_item(CMD_UNGATED, 3'd7, 8'hA5);
    send_item(CMD_NONE, 3'd7, 8'h00);
    send_item(CMD_UNGATED, 3'd0, 8'hFF);  // every key up
    settle_results();
  endtask

  task automatic test_debounce_gate();
    send_item(CMD_GATED, 3'd1, 8'h00);    // 0 ticks vs reset threshold: dropped
    write_reg(REG_DEBOUNCE, 16'd0);
    send_item(CMD_GATED, 3'd1, 8'h00);    // 0 > 0 fails
    send_item(CMD_TICK, 3'd0, 8'h00);
    send_item(CMD_GATED, 3'd1, 8'h0F);    // taken, counter cleared
    send_item(CMD_GATED, 3'd1, 8'hFF);    // dropped again
    send_item(CMD_TICK, 3'd5, 8'hFF);
    send_item(CMD_UNGATED, 3'd2, 8'h7F);  // counter untouched
    send_item(CMD_GATED, 3'd1, 8'hFF);
    settle_results();
  endtask

  task automatic test_column_mask();
    write_reg(REG_ACTIVE, 16'd0);
    send_item(CMD_UNGATED, 3'd3, 8'h00);  // nothing active, row stored as zero
    write_reg(REG_ACTIVE, 16'd3);
    send_item(CMD_UNGATED, 3'd3, 8'hFF);  // columns 0..2 only
    write_reg(REG_ACTIVE, 16'hFFF9);      // 9 clips to 8; upper data bits ignored
    send_item(CMD_UNGATED, 3'd3, 8'hFF);  // new columns compare against zero
    write_reg(REG_ACTIVE, 16'd15);
    send_item(CMD_UNGATED, 3'd3, 8'h00);
    write_reg(REG_ACTIVE, 16'd8);
  endtask

  task automatic test_gate_threshold();
    write_reg(REG_DEBOUNCE, 16'd0);
    send_item(CMD_TICK, 3'd0, 8'h00);
    send_item(CMD_GATED, 3'd4, 8'h3C);    // clears the counter
    write_reg(REG_DEBOUNCE, 16'd2);
    send_item(CMD_TICK, 3'd1, 8'h00);
    send_item(CMD_TICK, 3'd2, 8'h00);
    send_item(CMD_GATED, 3'd4, 8'hC3);    // count equals threshold: dropped
    send_item(CMD_TICK, 3'd3, 8'h00);
    send_item(CMD_GATED, 3'd4, 8'hC3);    // one above threshold: taken
    write_reg(REG_DEBOUNCE, 16'd1);
  endtask

  task automatic randomize_regs();
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) write_reg(REG_DEBOUNCE, 16'($urandom_range(3)));
    else if (pick < 9) write_reg(REG_DEBOUNCE, 16'($urandom_range(20)));
    else write_reg(REG_DEBOUNCE, 16'($urandom));
    if ($urandom_range(9) < 6) write_reg(REG_ACTIVE, 16'd8);
    else write_reg(REG_ACTIVE, 16'($urandom));
  endtask

  task automatic test_random_traffic(input int count);
    int         taken_cmds;
    int         pick;
    logic [1:0] cmd;
    logic [2:0] row;
    logic [7:0] sample;
    taken_cmds = 0;
    while (taken_cmds < count) begin
      if ($urandom_range(24) == 0) randomize_regs();
      pick = $urandom_range(99);
      if (pick < 30) cmd = CMD_TICK;
      else if (pick < 55) cmd = CMD_GATED;
      else if (pick < 90) cmd = CMD_UNGATED;
      else cmd = CMD_NONE;
      row = 3'($urandom_range(7));
      if ($urandom_range(2) == 0) begin
        sample = 8'($urandom);
      end else begin
        // a key or two moving against the current row state
        sample = model_levels[row] ^ (8'd1 << $urandom_range(7));
        if ($urandom_range(1) == 0) sample ^= 8'd1 << $urandom_range(7);
      end
      send_item(cmd, row, sample);
      if (cmd != CMD_NONE) taken_cmds++;
    end
    settle_results();
  endtask

  task automatic test_output_stall();
    write_reg(REG_ACTIVE, 16'd8);
    stall_request = STALL_CYCLES;
    for (int i = 0; i < 12; i++) send_item(CMD_UNGATED, 3'd5, (i % 2 == 0) ? 8'h00 : 8'hFF);
    settle_results();
    for (int i = 0; i < 6; i++) send_item(CMD_UNGATED, 3'($urandom_range(7)), 8'($urandom));
    settle_results();
  endtask

  initial begin
    for (int r = 0; r < 8; r++) model_levels[r] = 8'hFF;
    model_elapsed  = '0;
    model_debounce = DEBOUNCE_RESET;
    model_active   = ACTIVE_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct = 63;
    test_reset_levels();
    test_debounce_gate();
    test_column_mask();
    test_random_traffic(32);

    send_idle_pct = 63;
    recv_idle_pct = 9;
    test_random_traffic(32);
    test_output_stall();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(32);
    test_gate_threshold();
    settle_results();

    $display("covered %0d input beats (%0d tick/sample commands), %0d key events checked,",
             beats_sent, scan_cmds, events_checked);
    $display("%0d register writes, debounce gate and threshold edge, column masking",
             reg_writes);
    if (mismatches == 0) begin
      $display("key_matrix_change_detector_top regression: pass");
    end else begin
      $display("key_matrix_change_detector_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d key events outstanding", pending_events.size());
    $display("key_matrix_change_detector_top regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kmcd_pkg.sv
rtl/key_matrix_change_detector_top.sv
verif/tb_key_matrix_change_detector_top.sv
